// File: rtl/xbm_pkg.sv
`default_nettype none
package xbm_pkg;

    // Character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BRACE  = 8'h7B;
    localparam logic [7:0] CH_LOW_D  = 8'h64;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    localparam int          KW_LEN      = 6;
    localparam logic [39:0] SUFFIX_W    = "htdiw";   // "width", first char lowest
    localparam logic [47:0] SUFFIX_H    = "thgieh";  // "height", first char lowest
    localparam logic [16:0] LIT_CAP     = 17'h10000;
    localparam logic [16:0] MAX_DIMENSION = 17'd65535;
    localparam int          PADDR_W     = 2;
    localparam logic [PADDR_W-1:0] REG_REVERSE = '0;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_IMAGE  = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERROR  = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        HS_LINE_START   = 4'd0,
        HS_SKIP_LINE    = 4'd1,
        HS_AFTER_HASH   = 4'd2,
        HS_KEYWORD      = 4'd3,
        HS_AFTER_DEFINE = 4'd4,
        HS_NAME         = 4'd5,
        HS_BEFORE_NUM   = 4'd6,
        HS_AFTER_SIGN   = 4'd7,
        HS_NUM          = 4'd8,
        HS_SEEK_BRACE   = 4'd9
    } t_hstep;

    typedef enum logic [2:0] {
        LIT_NONE      = 3'd0,
        LIT_ZERO      = 3'd1,
        LIT_HEXPREFIX = 3'd2,
        LIT_OCTAL     = 3'd3,
        LIT_DECIMAL   = 3'd4,
        LIT_HEX       = 3'd5
    } t_radix;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    // Classified character from the front end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       digit;
        logic       alpha;
        logic       blank;
        logic       octal;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       num_space;
    } t_char_info;

    typedef struct packed {
        t_radix      radix;
        logic [16:0] value;
        logic [7:0]  low;
    } t_lit;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  pixel_byte;
        logic [15:0] row_index;
        logic [12:0] byte_column;
        logic        row_end;
        logic        image_done;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } t_result;

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = "d";
            3'd1:    ch = "e";
            3'd2:    ch = "f";
            3'd3:    ch = "i";
            3'd4:    ch = "n";
            3'd5:    ch = "e";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7-i] = v[i];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/xbm_ifs.sv
`default_nettype none
interface xbm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;
    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface xbm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  pixel_byte;
    logic [15:0] row_index;
    logic [12:0] byte_column;
    logic        row_end;
    logic        image_done;
    logic [15:0] image_width;
    logic [15:0] image_height;
    modport source (output valid, kind, pixel_byte, row_index, byte_column, row_end,
                    image_done, image_width, image_height, input ready);
    modport sink   (input valid, kind, pixel_byte, row_index, byte_column, row_end,
                    image_done, image_width, image_height, output ready);
endinterface
`default_nettype wire

// File: rtl/xbm_front.sv
`default_nettype none
module xbm_front (
    input  wire logic [7:0]         i_data,
    input  wire logic               i_last,
    output xbm_pkg::t_char_info     o_info
);
    import xbm_pkg::*;

    logic [7:0] c;
    assign c = i_data;

    // Classify the character for the parser
    always_comb begin
        o_info.data      = c;
        o_info.last      = i_last;
        o_info.digit     = (c >= "0") && (c <= "9");
        o_info.alpha     = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        o_info.blank     = (c == CH_SPACE) || (c == CH_TAB);
        o_info.octal     = (c >= "0") && (c <= "7");
        o_info.num_space = o_info.blank || (c == CH_LF) || (c == CH_CR) ||
                           (c == CH_VT) || (c == CH_FF);
        o_info.hex_ok    = 1'b0;
        o_info.hex_val   = 4'd0;
        if (o_info.digit) begin
            o_info.hex_ok  = 1'b1;
            o_info.hex_val = 4'(c - "0");
        end else if ((c >= "a") && (c <= "f")) begin
            o_info.hex_ok  = 1'b1;
            o_info.hex_val = 4'(c - "a" + 8'd10);
        end else if ((c >= "A") && (c <= "F")) begin
            o_info.hex_ok  = 1'b1;
            o_info.hex_val = 4'(c - "A" + 8'd10);
        end
    end

endmodule
`default_nettype wire

// File: rtl/xbm_queue.sv
`default_nettype none
module xbm_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  xbm_pkg::t_char_info     i_item,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output xbm_pkg::t_char_info     o_item
);
    import xbm_pkg::*;

    t_char_info r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");

endmodule
`default_nettype wire

// File: rtl/xbm_back.sv
`default_nettype none
module xbm_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_reverse,
    input  wire logic               i_valid,
    input  xbm_pkg::t_char_info     i_item,
    output logic                    o_pop,
    output logic                    o_res_valid,
    output xbm_pkg::t_result        o_res,
    input  wire logic               i_res_ready
);
    import xbm_pkg::*;

    typedef struct packed {
        logic [47:0] chars;
        logic [2:0]  len;
        logic        us;
        logic        ubl;
    } t_name;

    typedef struct packed {
        logic ok;
        t_lit lit;
    } t_feed;

    t_phase      r_phase, n_phase;
    t_hstep      r_hs, n_hs;
    logic [2:0]  r_kw, n_kw;
    t_name       r_name, n_name;
    logic        r_dimh, n_dimh;
    t_lit        r_lit, n_lit;
    logic        r_ws, n_ws, r_hseen, n_hseen;
    logic [15:0] r_wv, n_wv, r_hv, n_hv;
    logic [16:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic        r_out_valid;
    t_result     r_out;

    logic        fire;
    logic        res_valid;
    t_result     res;
    t_char_info  ci;
    t_feed       feed;
    logic        ln_nl;
    logic [16:0] e_col;
    logic [16:0] e_row;
    logic        e_re, e_done;
    logic [7:0]  e_pix;

    function automatic t_name name_char(input t_name nm, input logic [7:0] c);
        t_name r;
        r = nm;
        if (nm.us) r.ubl = 1'b1;
        if (c == CH_UNDER) begin
            r.us    = 1'b1;
            r.chars = '0;
            r.len   = 3'd0;
        end else if (nm.len < 3'd6) begin
            r.chars[8*nm.len +: 8] = c;
            r.len = nm.len + 3'd1;
        end else begin
            r.len = 3'd7;
        end
        return r;
    endfunction

    function automatic t_lit lit_add(input t_lit l, input t_radix rd, input logic [3:0] d);
        t_lit        r;
        logic [20:0] v;
        logic [7:0]  lo;
        v  = 21'(l.value);
        lo = l.low;
        unique case (rd)
            LIT_OCTAL:   begin v = v << 3; lo = lo << 3; end
            LIT_DECIMAL: begin v = (v << 3) + (v << 1); lo = (lo << 3) + (lo << 1); end
            default:     begin v = v << 4; lo = lo << 4; end
        endcase
        v = v + 21'(d);
        r.radix = rd;
        r.value = (v > 21'(LIT_CAP)) ? LIT_CAP : v[16:0];
        r.low   = lo + 8'(d);
        return r;
    endfunction

    function automatic t_lit lit_start(input t_char_info c);
        t_lit r;
        r.value = 17'(c.hex_val);
        r.low   = 8'(c.hex_val);
        r.radix = (c.data == CH_ZERO) ? LIT_ZERO : LIT_DECIMAL;
        return r;
    endfunction

    function automatic t_feed lit_feed(input t_lit l, input t_char_info c);
        t_feed f;
        f.ok  = 1'b0;
        f.lit = l;
        unique case (l.radix)
            LIT_ZERO: begin
                if (c.data == CH_LOW_X || c.data == CH_UP_X) begin
                    f.ok = 1'b1;
                    f.lit.radix = LIT_HEXPREFIX;
                end else if (c.octal) begin
                    f.ok = 1'b1;
                    f.lit = lit_add(l, LIT_OCTAL, c.hex_val);
                end
            end
            LIT_OCTAL: begin
                if (c.octal) begin
                    f.ok = 1'b1;
                    f.lit = lit_add(l, LIT_OCTAL, c.hex_val);
                end
            end
            LIT_DECIMAL: begin
                if (c.digit) begin
                    f.ok = 1'b1;
                    f.lit = lit_add(l, LIT_DECIMAL, c.hex_val);
                end
            end
            LIT_HEXPREFIX, LIT_HEX: begin
                if (c.hex_ok) begin
                    f.ok = 1'b1;
                    f.lit = lit_add(l, LIT_HEX, c.hex_val);
                end
            end
            default: f.ok = 1'b0;
        endcase
        return f;
    endfunction

    assign ci    = i_item;
    assign fire  = i_valid && (!r_out_valid || i_res_ready);
    assign o_pop = fire;
    assign feed  = lit_feed(r_lit, ci);
    assign ln_nl = (ci.data == CH_LF);

    // Pixel placement for a byte emitted now
    always_comb begin
        e_pix  = i_reverse ? rev8(r_lit.low) : r_lit.low;
        e_col  = r_col + 17'd8;
        e_row  = 17'(r_row) + 17'd1;
        e_re   = (e_col >= 17'(r_wv));
        e_done = e_re && (e_row >= 17'(r_hv));
    end

    // Parse one character
    always_comb begin
        n_phase = r_phase; n_hs = r_hs; n_kw = r_kw; n_name = r_name;
        n_dimh = r_dimh; n_lit = r_lit; n_ws = r_ws; n_hseen = r_hseen;
        n_wv = r_wv; n_hv = r_hv; n_col = r_col; n_row = r_row;
        res_valid = 1'b0;
        res = '0;
        res.kind = KIND_ERROR;
        res.image_width  = r_wv;
        res.image_height = r_hv;

        unique case (r_phase)
            PH_HEADER: begin
                if (ci.last) begin
                    n_phase = PH_ERROR; res_valid = 1'b1;
                end else if (r_hs == HS_SEEK_BRACE) begin
                    if (ci.data == CH_BRACE) begin
                        n_phase = PH_IMAGE;
                        n_col = '0;
                        n_row = '0;
                        n_lit.radix = LIT_NONE;
                        res_valid = 1'b1;
                        res.kind = KIND_HEADER;
                    end
                end else begin
                    logic err;
                    err = 1'b0;
                    unique case (r_hs)
                        HS_LINE_START: begin
                            if (ci.data == CH_HASH) n_hs = HS_AFTER_HASH;
                            else if (ln_nl) n_hs = (r_ws && r_hseen) ? HS_SEEK_BRACE
                                                                    : HS_LINE_START;
                            else n_hs = HS_SKIP_LINE;
                        end
                        HS_SKIP_LINE: begin
                            if (ln_nl) n_hs = (r_ws && r_hseen) ? HS_SEEK_BRACE
                                                                : HS_LINE_START;
                        end
                        HS_AFTER_HASH: begin
                            if (!ci.blank) begin
                                if (ci.data != CH_LOW_D) err = 1'b1;
                                else begin
                                    n_kw = 3'd1;
                                    n_hs = HS_KEYWORD;
                                end
                            end
                        end
                        HS_KEYWORD: begin
                            if (r_kw >= 3'(KW_LEN) || ci.data != kw_char(r_kw)) err = 1'b1;
                            else begin
                                n_kw = r_kw + 3'd1;
                                if (n_kw == 3'(KW_LEN)) n_hs = HS_AFTER_DEFINE;
                            end
                        end
                        HS_AFTER_DEFINE: begin
                            if (!ci.blank) begin
                                if (ci.data == CH_LF || ci.data == CH_CR) err = 1'b1;
                                else begin
                                    n_name = name_char('0, ci.data);
                                    n_hs = HS_NAME;
                                end
                            end
                        end
                        HS_NAME: begin
                            if (ci.data == CH_LF || ci.data == CH_CR) err = 1'b1;
                            else if (!ci.blank) n_name = name_char(r_name, ci.data);
                            else if (!r_name.ubl) err = 1'b1;
                            else if (r_name.len == 3'd5 && r_name.chars[39:0] == SUFFIX_W)
                                begin
                                n_dimh = 1'b0; n_hs = HS_BEFORE_NUM;
                            end else if (r_name.len == 3'd6 && r_name.chars == SUFFIX_H)
                                begin
                                n_dimh = 1'b1; n_hs = HS_BEFORE_NUM;
                            end else n_hs = HS_SKIP_LINE;
                        end
                        HS_BEFORE_NUM: begin
                            if (!ci.num_space) begin
                                if (ci.data == CH_PLUS) n_hs = HS_AFTER_SIGN;
                                else if (!ci.digit) err = 1'b1;
                                else begin
                                    n_lit = lit_start(ci);
                                    n_hs = HS_NUM;
                                end
                            end
                        end
                        HS_AFTER_SIGN: begin
                            if (!ci.digit) err = 1'b1;
                            else begin
                                n_lit = lit_start(ci);
                                n_hs = HS_NUM;
                            end
                        end
                        HS_NUM: begin
                            if (feed.ok) n_lit = feed.lit;
                            else if (r_lit.radix == LIT_HEXPREFIX || r_lit.value < 17'd1 ||
                                     r_lit.value > MAX_DIMENSION) err = 1'b1;
                            else begin
                                if (r_dimh) begin
                                    n_hv = r_lit.value[15:0]; n_hseen = 1'b1;
                                end else begin
                                    n_wv = r_lit.value[15:0]; n_ws = 1'b1;
                                end
                                n_lit.radix = LIT_NONE;
                                if (ln_nl) n_hs = (n_ws && n_hseen) ? HS_SEEK_BRACE
                                                                    : HS_LINE_START;
                                else n_hs = HS_SKIP_LINE;
                            end
                        end
                        default: err = 1'b1;
                    endcase
                    if (err) begin
                        n_phase = PH_ERROR; res_valid = 1'b1;
                    end
                end
            end
            PH_IMAGE: begin
                logic do_emit, then_fail;
                do_emit = 1'b0; then_fail = 1'b0;
                if (r_lit.radix == LIT_NONE) begin
                    if (ci.digit) n_lit = lit_start(ci);
                    else if (ci.alpha) begin
                        n_phase = PH_ERROR; res_valid = 1'b1;
                    end
                end else if (feed.ok) n_lit = feed.lit;
                else begin
                    do_emit = 1'b1;
                    then_fail = (r_lit.radix == LIT_HEXPREFIX) || ci.alpha;
                end
                if (do_emit) begin
                    res_valid = 1'b1;
                    res.kind = KIND_PIXEL;
                    res.pixel_byte = e_pix;
                    res.row_index = r_row;
                    res.byte_column = r_col[15:3];
                    res.row_end = e_re;
                    res.image_done = e_done;
                    n_lit.radix = LIT_NONE;
                    n_col = e_re ? 17'd0 : e_col;
                    if (e_re) n_row = e_row[15:0];
                    if (e_done) n_phase = PH_DONE;
                    else if (then_fail) begin
                        n_phase = PH_ERROR;
                        res = '0; res.kind = KIND_ERROR;
                        res.image_width = r_wv; res.image_height = r_hv;
                    end else if (ci.digit) n_lit = lit_start(ci);
                end
                if (ci.last && n_phase == PH_IMAGE) begin
                    n_phase = PH_ERROR; res_valid = 1'b1;
                    res = '0; res.kind = KIND_ERROR;
                    res.image_width = r_wv; res.image_height = r_hv;
                end
            end
            default: res_valid = 1'b0;
        endcase
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_hs <= HS_LINE_START; r_kw <= '0;
            r_name <= '0; r_dimh <= 1'b0; r_lit <= '{LIT_NONE, 17'd0, 8'd0};
            r_ws <= 1'b0; r_hseen <= 1'b0; r_wv <= '0; r_hv <= '0;
            r_col <= '0; r_row <= '0;
        end else if (fire) begin
            r_phase <= n_phase; r_hs <= n_hs; r_kw <= n_kw; r_name <= n_name;
            r_dimh <= n_dimh; r_lit <= n_lit; r_ws <= n_ws; r_hseen <= n_hseen;
            r_wv <= n_wv; r_hv <= n_hv; r_col <= n_col; r_row <= n_row;
        end
    end

    // Output register: load a new result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (fire && res_valid) r_out_valid <= 1'b1;
        else if (i_res_ready) r_out_valid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (fire && res_valid) r_out <= res;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_final_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE || r_phase == PH_ERROR) |=> $stable(r_phase))
        else $error("final phase left");
    a_pixel_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res_valid && res.kind == KIND_PIXEL) |-> (r_phase == PH_IMAGE))
        else $error("pixel outside image");
    a_done_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.image_done) |-> r_out.row_end)
        else $error("image done without row end");
    a_dims_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IMAGE) |-> (r_ws && r_hseen && r_wv != 16'd0))
        else $error("image phase without dimensions");

endmodule
`default_nettype wire

// File: rtl/xbm_bitmap_text_decoder.sv
`default_nettype none
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    data_byte, end_of_data
// o_out     out  valid/ready    kind, pixel_byte, row_index, byte_column, row_end,
//                               image_done, image_width, image_height
// apb       in   psel/penable   reverse_bits at byte address 0
//
// One text byte per cycle sustained while o_out is ready; a result reaches o_out
// after its byte is accepted by way of the queue, whose head the parser reads, and
// the output register, which loads the parser's result.
// The parser register update is the loop that sets this rate.
// Synchronous active-low reset; the block then waits for a header.
// Input and output stall independently through the queue and output register.
module xbm_bitmap_text_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    xbm_in_if.sink                           i_in,
    xbm_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [xbm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import xbm_pkg::*;

    t_char_info f_info, q_item;
    t_result    res;
    logic       q_full, q_valid, q_pop, push;
    logic       r_reverse;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = {31'd0, r_reverse};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_reverse <= 1'b0;
        else if (psel && penable && pwrite && (paddr == REG_REVERSE)) r_reverse <= pwdata[0];
    end

    assign i_in.ready = !q_full;
    assign push       = i_in.valid && !q_full;

    xbm_front u_front (
        .i_data (i_in.data_byte),
        .i_last (i_in.end_of_data),
        .o_info (f_info)
    );

    xbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_info),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    xbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_reverse   (r_reverse),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_res_valid (o_out.valid),
        .o_res       (res),
        .i_res_ready (o_out.ready)
    );

    assign o_out.kind         = res.kind;
    assign o_out.pixel_byte   = res.pixel_byte;
    assign o_out.row_index    = res.row_index;
    assign o_out.byte_column  = res.byte_column;
    assign o_out.row_end      = res.row_end;
    assign o_out.image_done   = res.image_done;
    assign o_out.image_width  = res.image_width;
    assign o_out.image_height = res.image_height;

endmodule
`default_nettype wire

// File: bench/tb_xbm_bitmap_text_decoder.sv
`timescale 1ns / 1ps
module tb_xbm_bitmap_text_decoder;
    import xbm_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    xbm_in_if  text_in ();
    xbm_out_if result_out ();

    xbm_bitmap_text_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_in),
        .o_out   (result_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_text_byte text_queue[$];
    t_result    expected_results[$];
    int         errors = 0;
    int         send_idle_pct = 23;
    int         recv_idle_pct = 76;
    int         hold_requests = 0;
    int         holds_started = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;

    // Decoder shadow state
    bit          rev_cfg;
    t_phase      ph;
    t_hstep      hs;
    logic [2:0]  kw_count;
    logic [47:0] sfx;
    int          sfx_len;
    bit          us_seen, us_before_last, dim_h;
    logic [16:0] lit_val;
    logic [7:0]  lit_low;
    t_radix      radix;
    bit          w_seen, h_seen;
    logic [15:0] w_val, h_val, rows;
    logic [16:0] col_bits;

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (is_digit(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] flip_byte(logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7-i] = v[i];
        return r;
    endfunction

    function automatic void shadow_reset();
        rev_cfg = 0; ph = PH_HEADER; hs = HS_LINE_START; kw_count = 0;
        sfx = 0; sfx_len = 0; us_seen = 0; us_before_last = 0; dim_h = 0;
        lit_val = 0; lit_low = 0; radix = LIT_NONE; w_seen = 0; h_seen = 0;
        w_val = 0; h_val = 0; col_bits = 0; rows = 0;
    endfunction

    function automatic void lit_add(int unsigned base, int unsigned d);
        int unsigned v;
        v = lit_val * base + d;
        lit_val = (v > LIT_CAP) ? LIT_CAP : v[16:0];
        lit_low = lit_low * base + d;
    endfunction

    function automatic void lit_start(logic [7:0] c);
        lit_val = c - "0";
        lit_low = c - "0";
        radix = (c == CH_ZERO) ? LIT_ZERO : LIT_DECIMAL;
    endfunction

    // Extend the current literal; return 0 when c cannot extend it
    function automatic bit lit_extend(logic [7:0] c);
        int h;
        case (radix)
            LIT_ZERO: begin
                if (c == CH_LOW_X || c == CH_UP_X) begin
                    radix = LIT_HEXPREFIX;
                    return 1;
                end
                if (c >= "0" && c <= "7") begin
                    radix = LIT_OCTAL;
                    lit_add(8, c - "0");
                    return 1;
                end
                return 0;
            end
            LIT_OCTAL: begin
                if (c >= "0" && c <= "7") begin
                    lit_add(8, c - "0");
                    return 1;
                end
                return 0;
            end
            LIT_DECIMAL: begin
                if (is_digit(c)) begin
                    lit_add(10, c - "0");
                    return 1;
                end
                return 0;
            end
            LIT_HEXPREFIX, LIT_HEX: begin
                h = hex_digit(c);
                if (h >= 0) begin
                    radix = LIT_HEX;
                    lit_add(16, h);
                    return 1;
                end
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void line_char(logic [7:0] c);
        if (c == CH_LF) hs = (w_seen && h_seen) ? HS_SEEK_BRACE : HS_LINE_START;
        else hs = HS_SKIP_LINE;
    endfunction

    function automatic void name_char(logic [7:0] c);
        if (us_seen) us_before_last = 1;
        if (c == CH_UNDER) begin
            us_seen = 1;
            sfx = 0;
            sfx_len = 0;
        end else if (sfx_len < 6) begin
            sfx[8*sfx_len +: 8] = c;
            sfx_len++;
        end else begin
            sfx_len = 7;
        end
    endfunction

    function automatic bit number_done();
        if (radix == LIT_HEXPREFIX) return 0;
        if (lit_val < 1 || lit_val > MAX_DIMENSION) return 0;
        if (dim_h) begin
            h_val = lit_val[15:0];
            h_seen = 1;
        end else begin
            w_val = lit_val[15:0];
            w_seen = 1;
        end
        radix = LIT_NONE;
        return 1;
    endfunction

    // Advance the header parser; return 1 on a malformed header
    function automatic bit header_char(logic [7:0] c);
        case (hs)
            HS_LINE_START: begin
                if (c == CH_HASH) hs = HS_AFTER_HASH;
                else line_char(c);
                return 0;
            end
            HS_SKIP_LINE: begin
                if (c == CH_LF) line_char(c);
                return 0;
            end
            HS_AFTER_HASH: begin
                if (is_blank(c)) return 0;
                if (c != CH_LOW_D) return 1;
                kw_count = 1;
                hs = HS_KEYWORD;
                return 0;
            end
            HS_KEYWORD: begin
                if (kw_count >= KW_LEN || c != kw_char(kw_count)) return 1;
                kw_count++;
                if (kw_count == KW_LEN) hs = HS_AFTER_DEFINE;
                return 0;
            end
            HS_AFTER_DEFINE: begin
                if (is_blank(c)) return 0;
                if (c == CH_LF || c == CH_CR) return 1;
                sfx = 0; sfx_len = 0; us_seen = 0; us_before_last = 0;
                hs = HS_NAME;
                name_char(c);
                return 0;
            end
            HS_NAME: begin
                if (c == CH_LF || c == CH_CR) return 1;
                if (!is_blank(c)) begin
                    name_char(c);
                    return 0;
                end
                if (!us_before_last) return 1;
                if (sfx_len == 5 && sfx[39:0] == SUFFIX_W) begin
                    dim_h = 0;
                    hs = HS_BEFORE_NUM;
                end else if (sfx_len == 6 && sfx == SUFFIX_H) begin
                    dim_h = 1;
                    hs = HS_BEFORE_NUM;
                end else begin
                    hs = HS_SKIP_LINE;
                end
                return 0;
            end
            HS_BEFORE_NUM: begin
                if (is_blank(c) || c == CH_LF || c == CH_CR || c == CH_VT || c == CH_FF)
                    return 0;
                if (c == CH_PLUS) begin
                    hs = HS_AFTER_SIGN;
                    return 0;
                end
                if (!is_digit(c)) return 1;
                lit_start(c);
                hs = HS_NUM;
                return 0;
            end
            HS_AFTER_SIGN: begin
                if (!is_digit(c)) return 1;
                lit_start(c);
                hs = HS_NUM;
                return 0;
            end
            HS_NUM: begin
                if (lit_extend(c)) return 0;
                if (!number_done()) return 1;
                line_char(c);
                return 0;
            end
            default: return 1;
        endcase
    endfunction

    function automatic t_result make_result(t_kind k);
        t_result r;
        r = '0;
        r.kind = k;
        r.image_width = w_val;
        r.image_height = h_val;
        return r;
    endfunction

    function automatic t_result error_result();
        ph = PH_ERROR;
        return make_result(KIND_ERROR);
    endfunction

    function automatic t_result pixel_result();
        t_result r;
        r = make_result(KIND_PIXEL);
        r.pixel_byte = rev_cfg ? flip_byte(lit_low) : lit_low;
        r.row_index = rows;
        r.byte_column = col_bits[15:3];
        radix = LIT_NONE;
        col_bits += 8;
        if (col_bits >= w_val) begin
            r.row_end = 1;
            col_bits = 0;
            rows++;
            if (rows >= h_val) begin
                r.image_done = 1;
                ph = PH_DONE;
            end
        end
        return r;
    endfunction

    // Predict the result, if any, of one accepted text byte
    function automatic void decode_text_byte(logic [7:0] c, logic last);
        t_result r;
        bit have;
        have = 0;
        if (ph == PH_DONE || ph == PH_ERROR) return;
        if (ph == PH_HEADER) begin
            if (last) begin
                expected_results.push_back(error_result());
            end else if (hs == HS_SEEK_BRACE) begin
                if (c == CH_BRACE) begin
                    ph = PH_IMAGE;
                    col_bits = 0;
                    rows = 0;
                    radix = LIT_NONE;
                    expected_results.push_back(make_result(KIND_HEADER));
                end
            end else if (header_char(c)) begin
                expected_results.push_back(error_result());
            end
            return;
        end
        if (radix == LIT_NONE) begin
            if (is_digit(c)) lit_start(c);
            else if (is_alpha(c)) begin
                r = error_result();
                have = 1;
            end
        end else if (!lit_extend(c)) begin
            have = 1;
            if (radix == LIT_HEXPREFIX || is_alpha(c)) begin
                r = pixel_result();
                if (ph != PH_DONE) r = error_result();
            end else begin
                r = pixel_result();
                if (ph == PH_IMAGE && is_digit(c)) lit_start(c);
            end
        end
        if (last && ph == PH_IMAGE) begin
            r = error_result();
            have = 1;
        end
        if (have) expected_results.push_back(r);
    endfunction

    // Text producer: offer queued bytes, predict at each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_in.valid <= 1'b0;
        end else begin
            if (text_in.valid && text_in.ready)
                decode_text_byte(text_in.data_byte, text_in.end_of_data);
            if (!text_in.valid || text_in.ready) begin
                if (text_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_text_byte b;
                    b = text_queue.pop_front();
                    text_in.valid <= 1'b1;
                    text_in.data_byte <= b.ch;
                    text_in.end_of_data <= b.last;
                end else begin
                    text_in.valid <= 1'b0;
                end
            end
        end
    end

    // Result consumer: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_out.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            result_out.ready <= 1'b0;
        end else if (holds_started < hold_requests) begin
            holds_started <= holds_started + 1;
            hold_left <= 300;
            result_out.ready <= 1'b0;
        end else begin
            result_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        end
    endtask

    // Compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && result_out.valid && result_out.ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, result_out.kind);
            end else begin
                t_result e;
                e = expected_results.pop_front();
                check_field("kind", e.kind, result_out.kind);
                check_field("pixel_byte", e.pixel_byte, result_out.pixel_byte);
                check_field("row_index", e.row_index, result_out.row_index);
                check_field("byte_column", e.byte_column, result_out.byte_column);
                check_field("row_end", e.row_end, result_out.row_end);
                check_field("image_done", e.image_done, result_out.image_done);
                check_field("image_width", e.image_width, result_out.image_width);
                check_field("image_height", e.image_height, result_out.image_height);
            end
        end
    end

    // Watchdog: end the run after a long stretch without any transaction
    always @(posedge i_clk) begin
        if ((text_in.valid && text_in.ready) || (result_out.valid && result_out.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_text(string s, bit last_at_end = 0);
        t_text_byte b;
        for (int i = 0; i < s.len(); i++) begin
            b.ch = s[i];
            b.last = last_at_end && (i == s.len() - 1);
            text_queue.push_back(b);
        end
    endtask

    task automatic push_raw(logic [7:0] c);
        t_text_byte b;
        b.ch = c;
        b.last = 1'b0;
        text_queue.push_back(b);
    endtask

    task automatic write_reverse(logic value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= REG_REVERSE; pwdata <= {31'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        rev_cfg = value;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (text_queue.size() != 0 || text_in.valid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Random well-formed pixel literals separated by blanks, commas and noise
    task automatic push_pixels(int count);
        int sep;
        logic [7:0] noise;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 5))
                0: push_text($sformatf("%0d", $urandom_range(0, 255)));
                1: push_text($sformatf("0%0o", $urandom_range(0, 255)));
                2: push_text($sformatf("0X%02X", $urandom_range(0, 255)));
                3: push_text($sformatf("%0d", $urandom));
                default: push_text($sformatf("0x%02x", $urandom_range(0, 255)));
            endcase
            sep = $urandom_range(1, 3);
            for (int k = 0; k < sep; k++) begin
                case ($urandom_range(0, 4))
                    0: push_raw(",");
                    1: push_raw(CH_SPACE);
                    2: push_raw(CH_LF);
                    3: push_raw(CH_TAB);
                    default: begin
                        do noise = $urandom_range(0, 255);
                        while (is_digit(noise) || is_alpha(noise));
                        push_raw(noise);
                    end
                endcase
            end
        end
    endtask

    initial begin
        shadow_reset();
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        text_in.valid = 1'b0; text_in.data_byte = '0; text_in.end_of_data = 1'b0;
        result_out.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reverse(1'b1);

        // Header: skipped line with high bytes, width, unrelated define, height
        push_text("/* xbm");
        push_raw(8'hFF);
        push_raw(8'h80);
        push_text(" */\n#define img_x_width +0x14\n");
        push_text("# \tdefine\tother_name 17\n");
        push_text("#define img_height\t\n 062 junk\nstatic char bits[] = {");
        // Directed pixels: extremes, every radix, split octal, long literal
        push_text(" 0x00, 0xFF, 255, 0377, 0778, 99999999, 0XaB, 0x1234, 7,\n");
        push_pixels(45);
        wait_drained();

        write_reverse(1'b0);
        send_idle_pct = 76;
        recv_idle_pct = 23;
        hold_requests = 1;
        push_pixels(45);
        wait_drained();

        write_reverse(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_pixels(49);
        // Last pixel followed by a stray letter completes the image; rest is ignored
        push_text("0x5Az };\n", 1'b1);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
